// File: rtl/lfds_pkg.sv
// Shared types, constants and register codes for the line-follow speed block.
package lfds_pkg;

	localparam int DEV_W     = 8;
	localparam int SPEED_W   = 8;
	localparam int GAIN_W    = 10;
	localparam int MAG_W     = 8;
	localparam int PROD_W    = 17;
	localparam int OUT_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;

	localparam int TICK_W    = 8;
	localparam int SEC_W     = 5;
	localparam int TIMER_W   = 7;

	localparam int TickWrap     = 200;
	localparam int StopSecond   = 20;
	localparam int ConfirmTicks = 100;
	localparam int StraightLim  = 5;
	localparam int SharpLim     = 15;

	// floor(p / 1000) == (p * RECIP_K) >> RECIP_SHIFT for every p below 2**PROD_W
	localparam int RECIP_SHIFT = 26;
	localparam int RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] RECIP_K = 17'd67109;
	localparam int QPROD_W     = PROD_W + RECIP_W;
	localparam int CUT_W       = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRAIGHT_SPEED = 3'd0,
		REG_HILL_SPEED     = 3'd1,
		REG_GENTLE_SPEED   = 3'd2,
		REG_SHARP_SPEED    = 3'd3,
		REG_GENTLE_GAIN    = 3'd4,
		REG_SHARP_GAIN     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SPEED_W-1:0] straight_speed;
		logic [SPEED_W-1:0] hill_speed;
		logic [SPEED_W-1:0] gentle_speed;
		logic [SPEED_W-1:0] sharp_speed;
		logic [GAIN_W-1:0]  gentle_gain;
		logic [GAIN_W-1:0]  sharp_gain;
	} cfg_t;

	typedef struct packed {
		logic [SPEED_W-1:0] base;
		logic [PROD_W-1:0]  prod;
		logic               slow_left;
		logic               slow_right;
		logic               zero;
		logic               stopped;
		logic               confirmed;
	} work_t;

endpackage

// File: rtl/line_follow_differential_speed.sv
// Top level of the line-follow differential wheel speed block.
// One request per control tick carries a signed line deviation and a hill flag, and
// yields one result with left and right wheel speed targets plus the stop and
// straight-confirmed flags. A new request is taken every clock cycle while results
// drain; each result passes through the registered stages in order (input register,
// control stage with the deviation-times-gain multiply, output stage with the
// reciprocal multiply that divides by 1000). While a result waits under stall, any
// empty stage behind it still takes a request, so up to three requests are held
// before the input stalls.
// The configuration registers may be written only while no request is in flight;
// they take effect for the next request.
module line_follow_differential_speed (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [lfds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfds_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [lfds_pkg::DEV_W-1:0] deviation,
	input  logic                             on_hill,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [lfds_pkg::OUT_W-1:0] left_speed,
	output logic signed [lfds_pkg::OUT_W-1:0] right_speed,
	output logic                             stopped,
	output logic                             straight_confirmed
);
	import lfds_pkg::*;

	cfg_t  cfg;
	work_t work_s2;

	logic                     s1_valid_q, s2_valid_q, out_valid_q;
	logic signed [DEV_W-1:0]  deviation_s1;
	logic                     on_hill_s1;
	logic                     out_free, s2_free, s1_free;
	logic                     take_in, adv_s2, adv_out;

	// Each stage may advance when the one after it is empty or emptying.
	assign out_free = !out_valid_q || !out_stall;
	assign s2_free  = !s2_valid_q || out_free;
	assign s1_free  = !s1_valid_q || s2_free;
	assign in_stall = !s1_free;
	assign take_in  = in_valid && s1_free;
	assign adv_s2   = s1_valid_q && s2_free;
	assign adv_out  = s2_valid_q && out_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Hold each stage's valid unless it fills or drains this cycle.
			if (take_in)
				s1_valid_q <= 1'b1;
			else if (adv_s2)
				s1_valid_q <= 1'b0;
			if (adv_s2)
				s2_valid_q <= 1'b1;
			else if (adv_out)
				s2_valid_q <= 1'b0;
			if (adv_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Capture the request payload.
	always_ff @(posedge clk) begin
		if (take_in) begin
			deviation_s1 <= deviation;
			on_hill_s1   <= on_hill;
		end
	end

	lfds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance the timing and straight-tracking state once per request.
	lfds_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv_s2),
		.deviation_s1 (deviation_s1),
		.on_hill_s1   (on_hill_s1),
		.cfg          (cfg),
		.work_s2      (work_s2)
	);

	lfds_out u_out (
		.clk                (clk),
		.adv                (adv_out),
		.work_s2            (work_s2),
		.left_speed         (left_speed),
		.right_speed        (right_speed),
		.stopped            (stopped),
		.straight_confirmed (straight_confirmed)
	);

endmodule

// File: rtl/lfds_cfg.sv
// Configuration register file for the line-follow speed block.
module lfds_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [lfds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfds_pkg::CFG_DAT_W-1:0]  cfg_data,
	output lfds_pkg::cfg_t                  cfg
);
	import lfds_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.straight_speed <= SPEED_W'(75);
			cfg_q.hill_speed     <= SPEED_W'(0);
			cfg_q.gentle_speed   <= SPEED_W'(75);
			cfg_q.sharp_speed    <= SPEED_W'(75);
			cfg_q.gentle_gain    <= GAIN_W'(220);
			cfg_q.sharp_gain     <= GAIN_W'(250);
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_STRAIGHT_SPEED: cfg_q.straight_speed <= cfg_data[SPEED_W-1:0];
				REG_HILL_SPEED:     cfg_q.hill_speed     <= cfg_data[SPEED_W-1:0];
				REG_GENTLE_SPEED:   cfg_q.gentle_speed   <= cfg_data[SPEED_W-1:0];
				REG_SHARP_SPEED:    cfg_q.sharp_speed    <= cfg_data[SPEED_W-1:0];
				REG_GENTLE_GAIN:    cfg_q.gentle_gain    <= cfg_data[GAIN_W-1:0];
				REG_SHARP_GAIN:     cfg_q.sharp_gain     <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/lfds_ctrl.sv
// Timing state, straight confirmation, curve classification and slowdown product.
module lfds_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic signed [lfds_pkg::DEV_W-1:0] deviation_s1,
	input  logic                            on_hill_s1,
	input  lfds_pkg::cfg_t                  cfg,
	output lfds_pkg::work_t                 work_s2
);
	import lfds_pkg::*;

	logic [TICK_W-1:0]  tick_q, tick_nx;
	logic [SEC_W-1:0]   sec_q, sec_nx;
	logic [TIMER_W-1:0] timer_q, timer_nx;
	logic               stop_q, stop_nx;
	logic               straight_q, straight_nx;
	logic               confirmed_q, confirmed_nx;
	logic               gentle_q, gentle_nx;

	logic [TICK_W:0]    tick_inc;
	logic [TIMER_W:0]   timer_inc;
	logic [MAG_W-1:0]   mag;
	logic [GAIN_W-1:0]  gain;
	logic [MAG_W+GAIN_W-1:0] prod_full;
	work_t              work;

	always_comb begin
		stop_nx  = stop_q | (sec_q > SEC_W'(StopSecond));

		tick_inc = {1'b0, tick_q} + 1'b1;
		if (tick_inc > (TICK_W+1)'(TickWrap)) begin
			tick_nx = '0;
			sec_nx  = (sec_q != '1) ? sec_q + 1'b1 : sec_q;
		end else begin
			tick_nx = tick_inc[TICK_W-1:0];
			sec_nx  = sec_q;
		end

		if (straight_q && !confirmed_q)
			timer_inc = {1'b0, timer_q} + 1'b1;
		else
			timer_inc = '0;
		confirmed_nx = confirmed_q | (straight_q && timer_inc > (TIMER_W+1)'(ConfirmTicks));
		timer_nx     = timer_inc[TIMER_W-1:0];

		straight_nx = straight_q;
		gentle_nx   = gentle_q;
		mag         = '0;
		gain        = '0;
		work        = '0;
		work.stopped   = stop_nx;
		work.confirmed = confirmed_nx;

		if (stop_nx) begin
			work.zero = 1'b1;
		end else if (deviation_s1 > -StraightLim && deviation_s1 < StraightLim) begin
			straight_nx = 1'b1;
			if (confirmed_nx)
				work.base = on_hill_s1 ? cfg.hill_speed : cfg.straight_speed;
			else
				work.base = gentle_q ? cfg.gentle_speed : cfg.sharp_speed;
		end else begin
			straight_nx = 1'b0;
			mag = deviation_s1[DEV_W-1] ? MAG_W'(-deviation_s1) : MAG_W'(deviation_s1);
			gentle_nx = (mag < MAG_W'(SharpLim));
			work.base = gentle_nx ? cfg.gentle_speed : cfg.sharp_speed;
			gain      = gentle_nx ? cfg.gentle_gain : cfg.sharp_gain;
			work.slow_left  = ~deviation_s1[DEV_W-1];
			work.slow_right = deviation_s1[DEV_W-1];
		end

		// magnitude never exceeds 128, so the product fits PROD_W bits
		prod_full = (MAG_W+GAIN_W)'(mag) * (MAG_W+GAIN_W)'(gain);
		work.prod = prod_full[PROD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			sec_q       <= '0;
			timer_q     <= '0;
			stop_q      <= 1'b0;
			straight_q  <= 1'b0;
			confirmed_q <= 1'b0;
			gentle_q    <= 1'b0;
		end else if (adv) begin
			tick_q      <= tick_nx;
			sec_q       <= sec_nx;
			timer_q     <= timer_nx;
			stop_q      <= stop_nx;
			straight_q  <= straight_nx;
			confirmed_q <= confirmed_nx;
			gentle_q    <= gentle_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			work_s2 <= work;
	end

endmodule

// File: rtl/lfds_out.sv
// Divide by 1000 through a reciprocal multiply, pick wheel targets, hold the result.
module lfds_out (
	input  logic                             clk,
	input  logic                             adv,
	input  lfds_pkg::work_t                  work_s2,
	output logic signed [lfds_pkg::OUT_W-1:0] left_speed,
	output logic signed [lfds_pkg::OUT_W-1:0] right_speed,
	output logic                             stopped,
	output logic                             straight_confirmed
);
	import lfds_pkg::*;

	logic [QPROD_W-1:0]     qprod;
	logic [CUT_W-1:0]       cut;
	logic signed [OUT_W-1:0] base_s;
	logic signed [OUT_W-1:0] slow_s;
	logic signed [OUT_W-1:0] left_nx, right_nx;

	always_comb begin
		qprod  = QPROD_W'(work_s2.prod) * QPROD_W'(RECIP_K);
		cut    = qprod[RECIP_SHIFT +: CUT_W];
		base_s = $signed({{(OUT_W-SPEED_W){1'b0}}, work_s2.base});
		slow_s = base_s - $signed({{(OUT_W-CUT_W){1'b0}}, cut});
		if (work_s2.zero) begin
			left_nx  = '0;
			right_nx = '0;
		end else begin
			left_nx  = work_s2.slow_left  ? slow_s : base_s;
			right_nx = work_s2.slow_right ? slow_s : base_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_speed         <= left_nx;
			right_speed        <= right_nx;
			stopped            <= work_s2.stopped;
			straight_confirmed <= work_s2.confirmed;
		end
	end

endmodule
